// ----- rtl/core/itp_pkg.sv -----
// ============================================================================
// itp_pkg
// Shared codes, stack entry layout and priority table for the infix to
// postfix converter.
// ============================================================================
`default_nettype none

package itp_pkg;

  // Field widths of the token and result channels
  localparam int unsigned CMD_W   = 4;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned ERR_W   = 3;
  localparam int unsigned FUNC_W  = 4;

  // Token commands
  localparam logic [CMD_W-1:0] CMD_OPERAND = 4'd0;
  localparam logic [CMD_W-1:0] CMD_LPAREN  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_RPAREN  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_FUNC    = 4'd3;
  localparam logic [CMD_W-1:0] CMD_POW     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_MUL     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_DIV     = 4'd6;
  localparam logic [CMD_W-1:0] CMD_PLUS    = 4'd7;
  localparam logic [CMD_W-1:0] CMD_MINUS   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_END     = 4'd9;

  // Result kinds; PAREN only lives on the stack
  localparam logic [KIND_W-1:0] KIND_OPERAND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FUNC    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POW     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MUL     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PLUS    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_MINUS   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_PAREN   = 3'd7;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE          = 3'd0;
  localparam logic [ERR_W-1:0] ERR_MISSING_OPEN  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_MISSING_CLOSE = 3'd2;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW      = 3'd3;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN       = 3'd4;

  // One operator stack word
  typedef struct packed {
    logic [FUNC_W-1:0] func_id;
    logic              unary;
    logic [KIND_W-1:0] kind;
  } stack_entry_t;

  // One result before the last flag is known
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               unary;
    logic [ERR_W-1:0]   err;
  } result_t;

  // Operator priority; the parenthesis ranks lowest and fences the stack
  function automatic logic [2:0] rank_of(input logic [KIND_W-1:0] kind);
    logic [2:0] rank;
    case (kind)
      KIND_FUNC:             rank = 3'd4;
      KIND_POW:              rank = 3'd3;
      KIND_MUL, KIND_DIV:    rank = 3'd2;
      KIND_PLUS, KIND_MINUS: rank = 3'd1;
      default:               rank = 3'd0;
    endcase
    return rank;
  endfunction

  // Turn a popped stack word into its postfix result
  function automatic result_t entry_result(input stack_entry_t e);
    result_t r;
    r.kind  = e.kind;
    r.value = (e.kind == KIND_FUNC) ? VALUE_W'(e.func_id) : '0;
    r.unary = (e.kind == KIND_PLUS || e.kind == KIND_MINUS) ? e.unary : 1'b0;
    r.err   = ERR_NONE;
    return r;
  endfunction

  // Error result: no token, only the code
  function automatic result_t error_result(input logic [ERR_W-1:0] code);
    result_t r;
    r.kind  = KIND_OPERAND;
    r.value = '0;
    r.unary = 1'b0;
    r.err   = code;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/itp_if.sv -----
// ============================================================================
// itp_if
// Valid/ready channels of the infix to postfix converter: the token stream
// in and the postfix result stream out.
// ============================================================================
`default_nettype none

interface itp_token_if;
  import itp_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [VALUE_W-1:0] token_value;

  modport source (output valid, output command, output token_value, input ready);
  modport sink   (input valid, input command, input token_value, output ready);
endinterface

interface itp_result_if;
  import itp_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  out_kind;
  logic [VALUE_W-1:0] out_value;
  logic               out_unary;
  logic [ERR_W-1:0]   error_code;
  logic               last;

  modport source (output valid, output out_kind, output out_value, output out_unary,
                  output error_code, output last, input ready);
  modport sink   (input valid, input out_kind, input out_value, input out_unary,
                  input error_code, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/infix_to_postfix_converter_unit.sv -----
// ============================================================================
// infix_to_postfix_converter_unit
// Shunting-yard converter: classified infix tokens in, postfix tokens out.
// ============================================================================
// Usage:
//   in_i carries one classified token per transfer (command, token_value).
//   out_o carries the postfix tokens and error results that the token
//   releases; last marks the final result of a token. A token that releases
//   nothing ('(' pushed, an operator pushed without popping, dropped token)
//   gives no transfer. The operator stack is a synchronous memory with one
//   read port and a registered read, so the pop loop moves one entry per
//   cycle unless a stalled receiver holds it. Typical expressions pop few
//   entries.
//   One token is in work at a time; in_i.ready is high while the unit waits.
//   Results pass through a holding register and an output register, so a
//   new token is taken while the last result still waits on out_o.
//   A stalled receiver stops the pop loop once both registers are full.
//   Reset empties the stack, clears the error state and makes the next sign
//   unary; the stack memory itself needs no clearing.
// ============================================================================
`default_nettype none

module infix_to_postfix_converter_unit
  import itp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH  = 16,
  parameter int unsigned HANDLE_WIDTH = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  itp_token_if.sink           in_i,
  itp_result_if.source        out_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_COUNT  = CW'(1);
  localparam logic [VALUE_W-1:0] HANDLE_MASK =
    (HANDLE_WIDTH >= VALUE_W) ? {VALUE_W{1'b1}} : VALUE_W'((64'd1 << HANDLE_WIDTH) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_PUSH,
    S_ERR,
    S_FIN
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      count_q;
  logic               next_unary_q;
  logic               in_error_q;
  logic [CMD_W-1:0]   cmd_q;
  stack_entry_t       new_entry_q;
  result_t            held_q;
  logic               held_valid_q;
  result_t            out_q;
  logic               out_last_q;
  logic               out_valid_q;

  stack_entry_t       stack_mem [STACK_DEPTH];
  stack_entry_t       rd_data_q;

  logic               accept;
  logic               full;
  logic               out_free;
  logic               can_produce;
  logic               produce;
  result_t            prod_res;
  logic               flush;
  logic               top_paren;
  logic               pop_take;
  logic               pop_emit;
  logic               pop_stall;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  stack_entry_t       wr_data;
  logic [CW-1:0]      cnt_m1;
  logic [CW-1:0]      cnt_m2;
  stack_entry_t       in_entry;
  stack_entry_t       paren_entry;

  // Handshake and slot status
  assign in_i.ready  = (state_q == S_IDLE);
  assign accept      = in_i.valid && (state_q == S_IDLE);
  assign full        = (count_q == FULL_COUNT);
  assign out_free    = !out_valid_q || out_o.ready;
  assign can_produce = !held_valid_q || out_free;
  assign cnt_m1      = count_q - ONE_COUNT;
  assign cnt_m2      = count_q - CW'(2);

  // Build the stack word of an incoming operator
  always_comb begin
    in_entry.kind    = KIND_W'(in_i.command - CMD_W'(2));
    in_entry.func_id = (in_i.command == CMD_FUNC) ? in_i.token_value[FUNC_W-1:0] : '0;
    in_entry.unary   = (in_i.command == CMD_PLUS || in_i.command == CMD_MINUS)
                       ? next_unary_q : 1'b0;
    paren_entry         = '0;
    paren_entry.kind    = KIND_PAREN;
  end

  // Decide on the entry read from the top of the stack
  always_comb begin
    top_paren = (rd_data_q.kind == KIND_PAREN);
    case (cmd_q)
      CMD_END, CMD_RPAREN: pop_take = !top_paren;
      default:             pop_take = (rank_of(rd_data_q.kind) >= rank_of(new_entry_q.kind));
    endcase
    pop_emit  = (cmd_q == CMD_END) || pop_take;
    pop_stall = pop_emit && !can_produce;
  end

  // Results that enter the holding register this cycle
  always_comb begin
    produce  = 1'b0;
    prod_res = error_result(ERR_NONE);
    flush    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept && !in_error_q) begin
          case (in_i.command)
            CMD_OPERAND: begin
              produce        = 1'b1;
              prod_res.kind  = KIND_OPERAND;
              prod_res.value = in_i.token_value & HANDLE_MASK;
            end
            CMD_LPAREN: begin
              produce  = full;
              prod_res = error_result(ERR_OVERFLOW);
            end
            CMD_RPAREN, CMD_FUNC, CMD_POW, CMD_MUL, CMD_DIV, CMD_PLUS, CMD_MINUS,
            CMD_END: ;
            default: begin
              produce  = 1'b1;
              prod_res = error_result(ERR_UNKNOWN);
            end
          endcase
        end
      end
      S_POP: begin
        produce  = pop_emit && can_produce;
        prod_res = (cmd_q == CMD_END && top_paren) ? error_result(ERR_MISSING_CLOSE)
                                                   : entry_result(rd_data_q);
      end
      S_ERR: begin
        produce  = can_produce;
        prod_res = error_result(ERR_MISSING_OPEN);
      end
      S_PUSH: begin
        produce  = full && can_produce;
        prod_res = error_result(ERR_OVERFLOW);
      end
      S_FIN: begin
        flush = held_valid_q && out_free;
      end
      default: ;
    endcase
  end

  // Stack memory ports; a read and a write never fall in the same cycle
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_m1[AW-1:0];
    wr_en   = 1'b0;
    wr_data = new_entry_q;
    if (accept && !in_error_q && count_q != '0) begin
      case (in_i.command)
        CMD_RPAREN, CMD_FUNC, CMD_POW, CMD_MUL, CMD_DIV, CMD_PLUS, CMD_MINUS,
        CMD_END: rd_en = 1'b1;
        default: ;
      endcase
    end
    if (state_q == S_POP && !pop_stall && pop_take && count_q != ONE_COUNT) begin
      rd_en   = 1'b1;
      rd_addr = cnt_m2[AW-1:0];
    end
    if (accept && !in_error_q && in_i.command == CMD_LPAREN && !full) begin
      wr_en   = 1'b1;
      wr_data = paren_entry;
    end
    if (state_q == S_PUSH && !full) begin
      wr_en = 1'b1;
    end
  end

  // Operator stack storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[count_q[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= stack_mem[rd_addr];
    end
  end

  // Sequencer, stack pointer, holding and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      next_unary_q <= 1'b1;
      in_error_q   <= 1'b0;
      cmd_q        <= CMD_OPERAND;
      new_entry_q  <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      out_q        <= '0;
      out_last_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // Drop a taken result, then load new ones
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (produce) begin
        if (held_valid_q) begin
          out_q       <= held_q;
          out_last_q  <= 1'b0;
          out_valid_q <= 1'b1;
        end
        held_q       <= prod_res;
        held_valid_q <= 1'b1;
      end
      if (flush) begin
        out_q        <= held_q;
        out_last_q   <= 1'b1;
        out_valid_q  <= 1'b1;
        held_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q       <= in_i.command;
            new_entry_q <= in_entry;
            if (in_i.command == CMD_END) begin
              if (in_error_q || count_q == '0) begin
                count_q      <= '0;
                next_unary_q <= 1'b1;
                in_error_q   <= 1'b0;
              end else begin
                state_q <= S_POP;
              end
            end else if (!in_error_q) begin
              case (in_i.command)
                CMD_OPERAND: begin
                  next_unary_q <= 1'b0;
                  state_q      <= S_FIN;
                end
                CMD_LPAREN: begin
                  if (full) begin
                    in_error_q <= 1'b1;
                    state_q    <= S_FIN;
                  end else begin
                    count_q      <= count_q + ONE_COUNT;
                    next_unary_q <= 1'b1;
                  end
                end
                CMD_RPAREN: begin
                  state_q <= (count_q == '0) ? S_ERR : S_POP;
                end
                CMD_FUNC, CMD_POW, CMD_MUL, CMD_DIV, CMD_PLUS, CMD_MINUS: begin
                  state_q <= (count_q == '0) ? S_PUSH : S_POP;
                end
                default: begin
                  in_error_q <= 1'b1;
                  state_q    <= S_FIN;
                end
              endcase
            end
          end
        end
        S_POP: begin
          if (!pop_stall) begin
            case (cmd_q)
              CMD_END: begin
                if (top_paren || count_q == ONE_COUNT) begin
                  count_q      <= '0;
                  next_unary_q <= 1'b1;
                  in_error_q   <= 1'b0;
                  state_q      <= S_FIN;
                end else begin
                  count_q <= cnt_m1;
                end
              end
              CMD_RPAREN: begin
                count_q <= cnt_m1;
                if (top_paren) begin
                  next_unary_q <= 1'b0;
                  state_q      <= S_FIN;
                end else if (count_q == ONE_COUNT) begin
                  state_q <= S_ERR;
                end
              end
              default: begin
                if (pop_take) begin
                  count_q <= cnt_m1;
                  if (count_q == ONE_COUNT) begin
                    state_q <= S_PUSH;
                  end
                end else begin
                  state_q <= S_PUSH;
                end
              end
            endcase
          end
        end
        S_ERR: begin
          if (can_produce) begin
            in_error_q <= 1'b1;
            state_q    <= S_FIN;
          end
        end
        S_PUSH: begin
          if (full) begin
            if (can_produce) begin
              in_error_q <= 1'b1;
              state_q    <= S_FIN;
            end
          end else begin
            count_q      <= count_q + ONE_COUNT;
            next_unary_q <= 1'b0;
            state_q      <= S_FIN;
          end
        end
        S_FIN: begin
          if (!held_valid_q || out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Output channel
  assign out_o.valid      = out_valid_q;
  assign out_o.out_kind   = out_q.kind;
  assign out_o.out_value  = out_q.value;
  assign out_o.out_unary  = out_q.unary;
  assign out_o.error_code = out_q.err;
  assign out_o.last       = out_last_q;

  // A token starts only with nothing left in the holding register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !held_valid_q)
    else $error("holding register not empty while waiting for a token");

  // The stack pointer stays within the memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_COUNT)
    else $error("stack pointer beyond stack depth");

  // The single memory port pair is never read and written in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("stack read and write in the same cycle");

  // A held result is never dropped: it leaves only toward the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_valid_q && !produce && !flush) |=> held_valid_q)
    else $error("held result lost");

endmodule

`default_nettype wire

// ----- dv/tb_infix_to_postfix_converter_unit.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_infix_to_postfix_converter_unit
// Self-checking bench for the shunting-yard converter. A behavioral stack
// machine predicts the postfix tokens and error results that each accepted
// token releases. Directed token runs cover the field extremes, every command
// and the error paths. Random well-formed expressions, deep nesting
// (overflow) and noise follow under several handshake pressure phases.
// ============================================================================

module tb_infix_to_postfix_converter_unit;
  import itp_pkg::*;

  localparam int unsigned OP_STACK_DEPTH = 16;
  localparam int unsigned RANDOM_TOKENS  = 170;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned CYCLE_LIMIT    = 2_000_000;

  // Commands outside the classified set
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_FIRST = 4'd10;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_LAST  = 4'd15;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               unary;
    logic [ERR_W-1:0]   err;
    logic               last;
  } postfix_token_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
  } infix_token_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  itp_token_if  tok_if ();
  itp_result_if res_if ();

  infix_to_postfix_converter_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tok_if),
    .out_o  (res_if)
  );

  // Predicted converter state
  stack_entry_t  op_stack [OP_STACK_DEPTH];
  int unsigned   op_depth;
  logic          sign_is_unary;
  logic          dropping;

  postfix_token_t postfix_expected [$];
  infix_token_t   infix_plan [$];

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned tokens_sent;
  int unsigned results_checked;
  int unsigned error_results;
  int unsigned fail_count;
  int unsigned cycle_count;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------
  function automatic int unsigned precedence(input logic [KIND_W-1:0] kind);
    case (kind)
      KIND_FUNC:             return 4;
      KIND_POW:              return 3;
      KIND_MUL, KIND_DIV:    return 2;
      KIND_PLUS, KIND_MINUS: return 1;
      default:               return 0;
    endcase
  endfunction

  function automatic void emit_token(input logic [KIND_W-1:0] kind,
                                     input logic [VALUE_W-1:0] value,
                                     input logic unary, input logic [ERR_W-1:0] err);
    postfix_token_t t;
    t.kind  = kind;
    t.value = value;
    t.unary = unary;
    t.err   = err;
    t.last  = 1'b0;
    postfix_expected = {postfix_expected, t};
  endfunction

  function automatic void emit_popped(input stack_entry_t e);
    logic [VALUE_W-1:0] value;
    logic               unary;
    value = (e.kind == KIND_FUNC) ? VALUE_W'(e.func_id) : '0;
    unary = (e.kind == KIND_PLUS || e.kind == KIND_MINUS) ? e.unary : 1'b0;
    emit_token(e.kind, value, unary, ERR_NONE);
  endfunction

  function automatic void enter_error(input logic [ERR_W-1:0] code);
    emit_token(KIND_OPERAND, '0, 1'b0, code);
    dropping = 1'b1;
  endfunction

  function automatic void reset_expression();
    op_depth      = 0;
    sign_is_unary = 1'b1;
    dropping      = 1'b0;
  endfunction

  // Work out the postfix tokens released by one accepted infix token
  function automatic void predict_postfix(input logic [CMD_W-1:0] cmd,
                                          input logic [VALUE_W-1:0] value);
    int unsigned    queued;
    stack_entry_t   top;
    stack_entry_t   pushed;
    logic           found;
    queued = postfix_expected.size();
    if (cmd == CMD_END) begin
      // Flush up to the first open paren, then start a fresh expression
      if (!dropping) begin
        while (op_depth > 0) begin
          top = op_stack[op_depth-1];
          op_depth--;
          if (top.kind == KIND_PAREN) begin
            emit_token(KIND_OPERAND, '0, 1'b0, ERR_MISSING_CLOSE);
            break;
          end
          emit_popped(top);
        end
      end
      reset_expression();
    end else if (dropping) begin
      // drop everything until the end token
    end else if (cmd == CMD_OPERAND) begin
      emit_token(KIND_OPERAND, value, 1'b0, ERR_NONE);
      sign_is_unary = 1'b0;
    end else if (cmd == CMD_LPAREN) begin
      if (op_depth >= OP_STACK_DEPTH) begin
        enter_error(ERR_OVERFLOW);
      end else begin
        pushed = '0;
        pushed.kind = KIND_PAREN;
        op_stack[op_depth] = pushed;
        op_depth++;
        sign_is_unary = 1'b1;
      end
    end else if (cmd == CMD_RPAREN) begin
      found = 1'b0;
      while (op_depth > 0) begin
        top = op_stack[op_depth-1];
        op_depth--;
        if (top.kind == KIND_PAREN) begin
          found = 1'b1;
          break;
        end
        emit_popped(top);
      end
      if (!found) begin
        enter_error(ERR_MISSING_OPEN);
      end else begin
        sign_is_unary = 1'b0;
      end
    end else if (cmd >= CMD_FUNC && cmd <= CMD_MINUS) begin
      pushed = '0;
      pushed.kind = KIND_W'(cmd - 4'd2);
      // Pop everything that binds at least as tightly
      while (op_depth > 0 &&
             precedence(op_stack[op_depth-1].kind) >= precedence(pushed.kind)) begin
        emit_popped(op_stack[op_depth-1]);
        op_depth--;
      end
      if (pushed.kind == KIND_FUNC) pushed.func_id = value[FUNC_W-1:0];
      if (pushed.kind == KIND_PLUS || pushed.kind == KIND_MINUS) pushed.unary = sign_is_unary;
      if (op_depth >= OP_STACK_DEPTH) begin
        enter_error(ERR_OVERFLOW);
      end else begin
        op_stack[op_depth] = pushed;
        op_depth++;
        sign_is_unary = 1'b0;
      end
    end else begin
      enter_error(ERR_UNKNOWN);
    end
    // Mark the final token of this item
    if (postfix_expected.size() > queued) begin
      postfix_expected[postfix_expected.size() - 1].last = 1'b1;
    end
  endfunction

  // ------------------------------------------------------------------------
  // Token driver: drive at the falling edge, transfer at the rising edge
  // ------------------------------------------------------------------------
  task automatic send_token(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
    if ($urandom_range(99) < src_idle_pct) begin
      tok_if.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    tok_if.valid       <= 1'b1;
    tok_if.command     <= cmd;
    tok_if.token_value <= value;
    do @(posedge clk_i); while (!tok_if.ready);
    predict_postfix(cmd, value);
    tokens_sent++;
    @(negedge clk_i);
  endtask

  // Receiver stalls
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // ------------------------------------------------------------------------
  // Result checker
  // ------------------------------------------------------------------------
  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    postfix_token_t exp_tok;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (postfix_expected.size() == 0) begin
        $error("unexpected result transfer: kind %0d value %0d error %0d",
               res_if.out_kind, res_if.out_value, res_if.error_code);
        fail_count++;
      end else begin
        exp_tok = postfix_expected.pop_front();
        check_field("out_kind",   exp_tok.kind,  res_if.out_kind);
        check_field("out_value",  exp_tok.value, res_if.out_value);
        check_field("out_unary",  exp_tok.unary, res_if.out_unary);
        check_field("error_code", exp_tok.err,   res_if.error_code);
        check_field("last",       exp_tok.last,  res_if.last);
        results_checked++;
        if (exp_tok.err != ERR_NONE) error_results++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_infix_to_postfix_converter_unit failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Random token plans
  // ------------------------------------------------------------------------
  function automatic void plan_token(input logic [CMD_W-1:0] cmd,
                                     input logic [VALUE_W-1:0] value);
    infix_token_t t;
    t.cmd   = cmd;
    t.value = value;
    infix_plan = {infix_plan, t};
  endfunction

  function automatic logic [CMD_W-1:0] random_sign();
    return $urandom_range(1) ? CMD_PLUS : CMD_MINUS;
  endfunction

  // One operand, signed term, parenthesized group or function call
  function automatic void plan_term(input int unsigned depth);
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 5 || depth >= 3) begin
      plan_token(CMD_OPERAND, VALUE_W'($urandom));
    end else if (pick < 7) begin
      plan_token(random_sign(), VALUE_W'($urandom));
      plan_term(depth + 1);
    end else begin
      if (pick == 9) plan_token(CMD_FUNC, VALUE_W'($urandom));
      plan_token(CMD_LPAREN, VALUE_W'($urandom));
      plan_expr(depth + 1);
      plan_token(CMD_RPAREN, VALUE_W'($urandom));
    end
  endfunction

  function automatic void plan_expr(input int unsigned depth);
    int unsigned ops;
    ops = $urandom_range(3);
    plan_term(depth);
    repeat (ops) begin
      plan_token(CMD_W'(CMD_POW + $urandom_range(4)), VALUE_W'($urandom));
      plan_term(depth);
    end
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // -a + b * f(c ^ d / e), function id above 15, handle extremes
  task automatic test_operator_mix();
    send_token(CMD_MINUS,   16'h0000);
    send_token(CMD_OPERAND, 16'hFFFF);
    send_token(CMD_PLUS,    16'hFFFF);
    send_token(CMD_OPERAND, 16'h0000);
    send_token(CMD_MUL,     16'h0000);
    send_token(CMD_FUNC,    16'hFFFF);
    send_token(CMD_LPAREN,  16'h0000);
    send_token(CMD_OPERAND, 16'hA5A5);
    send_token(CMD_POW,     16'h0000);
    send_token(CMD_OPERAND, 16'h5A5A);
    send_token(CMD_DIV,     16'h0000);
    send_token(CMD_OPERAND, 16'h0001);
    send_token(CMD_RPAREN,  16'h0000);
    send_token(CMD_END,     16'hFFFF);
  endtask

  // Stray close paren, dropping, unclosed open paren, end on empty stack
  task automatic test_paren_errors();
    send_token(CMD_RPAREN,  16'h0000);
    send_token(CMD_OPERAND, 16'h1234);
    send_token(CMD_END,     16'h0000);
    send_token(CMD_LPAREN,  16'h0000);
    send_token(CMD_PLUS,    16'h0000);
    send_token(CMD_OPERAND, 16'h8000);
    send_token(CMD_MINUS,   16'h0000);
    send_token(CMD_OPERAND, 16'h7FFF);
    send_token(CMD_END,     16'h0000);
    send_token(CMD_END,     16'h0000);
  endtask

  // Lowest and highest unknown commands
  task automatic test_unknown_tokens();
    send_token(CMD_OPERAND,       16'h00FF);
    send_token(CMD_UNKNOWN_FIRST, 16'h0000);
    send_token(CMD_PLUS,          16'h0000);
    send_token(CMD_END,           16'h0000);
    send_token(CMD_UNKNOWN_LAST,  16'hFFFF);
    send_token(CMD_END,           16'h0000);
  endtask

  // Mostly well-formed expressions, some corrupted, deep nesting and noise
  task automatic test_random_expressions(input int unsigned count,
                                         input int unsigned src_pct,
                                         input int unsigned snk_pct);
    int unsigned  target;
    int unsigned  pick;
    int unsigned  spot;
    infix_token_t t;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    target = tokens_sent + count;
    while (tokens_sent < target) begin
      infix_plan.delete();
      pick = $urandom_range(99);
      if (pick < 70) begin
        plan_expr(0);
        // Break some expressions with a random token
        if ($urandom_range(3) == 0) begin
          spot = $urandom_range(infix_plan.size() - 1);
          infix_plan[spot].cmd = CMD_W'($urandom_range(CMD_UNKNOWN_LAST));
        end
      end else if (pick < 80) begin
        // Nest deep, at times deep enough to fill or overflow the stack
        repeat ($urandom_range(8, 9)) begin
          plan_token(CMD_LPAREN, VALUE_W'($urandom));
          if ($urandom_range(1)) plan_token(random_sign(), VALUE_W'($urandom));
        end
        plan_token(CMD_OPERAND, VALUE_W'($urandom));
        if ($urandom_range(1)) plan_token(CMD_RPAREN, VALUE_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          plan_token(CMD_W'($urandom_range(CMD_UNKNOWN_LAST)), VALUE_W'($urandom));
        end
      end
      plan_token(CMD_END, VALUE_W'($urandom));
      foreach (infix_plan[i]) begin
        t = infix_plan[i];
        send_token(t.cmd, t.value);
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    tok_if.valid       = 1'b0;
    tok_if.command     = CMD_OPERAND;
    tok_if.token_value = '0;
    res_if.ready       = 1'b0;
    src_idle_pct       = 0;
    snk_stall_pct      = 0;
    tokens_sent        = 0;
    results_checked    = 0;
    error_results      = 0;
    fail_count         = 0;
    cycle_count        = 0;
    reset_expression();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_operator_mix();
    test_paren_errors();
    test_unknown_tokens();
    test_random_expressions(RANDOM_TOKENS * 3 / 10, 0, 0);
    test_random_expressions(RANDOM_TOKENS / 4, 88, 0);
    test_random_expressions(RANDOM_TOKENS / 4, 0, 88);
    test_random_expressions(RANDOM_TOKENS / 5, 21, 21);

    // Drain outstanding results, then let the pipeline settle
    tok_if.valid <= 1'b0;
    while (postfix_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d infix tokens and %0d postfix results, %0d of them errors,",
             tokens_sent, results_checked, error_results);
    $display("over directed, well-formed, nested, noisy and back-pressured runs.");
    if (fail_count == 0) begin
      $display("tb_infix_to_postfix_converter_unit passed");
    end else begin
      $display("tb_infix_to_postfix_converter_unit failed");
    end
    $finish;
  end

endmodule
